// File: design/nps_pkg.sv
// shared types and constants for the nearest palette color search block
package nps_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int DIST_W              = 18;

	localparam logic       REQ_LOAD  = 1'b0;
	localparam logic       REQ_QUERY = 1'b1;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic ram_write;
		logic capture;
		logic scan_start;
		logic scan_step;
		logic out_pack;
		logic out_query;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic pipe_busy;
	} dp_status_t;

endpackage

// File: design/nearest_palette_color_search.sv
// top level of the nearest palette color search block
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | req_type, entry_index, red_in, green_in,
//          |                      | blue_in, color_code
//  out     | out_valid / out_ready| packed_rgba, nearest_index
//
// a load writes the entry, and its packed word goes to the output register at
// the transfer. in a query the scan reads one palette entry per cycle from the
// single read port, then a four-stage distance and minimum pipeline drains.
// reset clears the controller, the scan counter and pipeline valid bits only;
// palette contents are undefined until loaded. a new item is taken while the
// controller is idle and the result slot is empty or being taken, and a stalled
// output holds its result and blocks the next transfer.
module nearest_palette_color_search #(
	parameter int PALETTE_ENTRIES = nps_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  entry_index,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [14:0] color_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] packed_rgba,
	output logic [7:0]  nearest_index
);
	import nps_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	nps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	nps_dp #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.entry_index  (entry_index),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.color_code   (color_code),
		.packed_rgba  (packed_rgba),
		.nearest_index(nearest_index)
	);

`ifndef SYNTHESIS
	// a load answers in the very next cycle
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (req_type == REQ_LOAD)) |=> out_valid)
		else $error("load transfer produced no result");

	// no new transfer while a query scan is under way
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (req_type == REQ_QUERY)) |=> !in_ready)
		else $error("input ready during query scan");

	// a query result carries no packed word
	a_query_packed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_query |=> (packed_rgba == 32'd0))
		else $error("query result has nonzero packed word");
`endif

endmodule

// File: design/nps_ram.sv
// generic single-port-write, registered-read RAM
module nps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/nps_dp.sv
// datapath: palette store, distance pipeline, running minimum and result registers
module nps_dp #(
	parameter int PALETTE_ENTRIES = nps_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nps_pkg::ctrl_cmd_t     cmd,
	output nps_pkg::dp_status_t    status,
	input  logic [7:0]             entry_index,
	input  logic [7:0]             red_in,
	input  logic [7:0]             green_in,
	input  logic [7:0]             blue_in,
	input  logic [14:0]            color_code,
	output logic [31:0]            packed_rgba,
	output logic [7:0]             nearest_index
);
	import nps_pkg::*;

	localparam int         AW       = $clog2(PALETTE_ENTRIES);
	localparam logic [8:0] NUM      = 9'(PALETTE_ENTRIES);
	localparam logic [8:0] LAST_IDX = 9'(PALETTE_ENTRIES - 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

	logic [7:0]        red_q, green_q, blue_q;
	logic [AW-1:0]     scan_cnt_q;
	logic [23:0]       rdata;
	logic              idx_ok;
	logic              v_s1, v_s2, v_s3;
	logic [AW-1:0]     idx_s1, idx_s2, idx_s3;
	logic [7:0]        dr_s2, dg_s2, db_s2;
	logic [15:0]       sqr_s3, sqg_s3, sqb_s3;
	logic [DIST_W-1:0] dist_sum;
	logic [DIST_W-1:0] best_q;
	logic [AW-1:0]     best_idx_q;
	logic [31:0]       packed_q;
	logic [7:0]        nearest_q;
	logic [7:0]        alpha;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	assign idx_ok = {1'b0, entry_index} < NUM;
	assign alpha  = ({1'b0, entry_index} == LAST_IDX) ? ALPHA_CLEAR : ALPHA_OPAQUE;

	nps_ram #(
		.WIDTH(24),
		.DEPTH(PALETTE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.ram_write && idx_ok),
		.waddr(entry_index[AW-1:0]),
		.wdata({blue_in, green_in, red_in}),
		.re   (cmd.scan_step),
		.raddr(scan_cnt_q),
		.rdata(rdata)
	);

	// query color expanded as value*8+4
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			red_q   <= {color_code[4:0], 3'b100};
			green_q <= {color_code[9:5], 3'b100};
			blue_q  <= {color_code[14:10], 3'b100};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_cnt_q <= '0;
			end else if (cmd.scan_step) begin
				scan_cnt_q <= scan_cnt_q + AW'(1);
			end
			v_s1 <= cmd.scan_step;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// read data lines up with idx_s1
	always_ff @(posedge clk) begin
		idx_s1 <= scan_cnt_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		dr_s2  <= abs_diff(red_q, rdata[7:0]);
		dg_s2  <= abs_diff(green_q, rdata[15:8]);
		db_s2  <= abs_diff(blue_q, rdata[23:16]);
		sqr_s3 <= 16'(dr_s2) * 16'(dr_s2);
		sqg_s3 <= 16'(dg_s2) * 16'(dg_s2);
		sqb_s3 <= 16'(db_s2) * 16'(db_s2);
	end

	assign dist_sum = DIST_W'(sqr_s3) + DIST_W'(sqg_s3) + DIST_W'(sqb_s3);

	// strict less-than keeps the lowest index on a tie
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			best_q     <= DIST_MAX;
			best_idx_q <= '0;
		end else if (v_s3 && (dist_sum < best_q)) begin
			best_q     <= dist_sum;
			best_idx_q <= idx_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_pack) begin
			packed_q  <= {alpha, blue_in, green_in, red_in};
			nearest_q <= '0;
		end else if (cmd.out_query) begin
			packed_q  <= '0;
			nearest_q <= 8'(best_idx_q);
		end
	end

	assign status.scan_last = (scan_cnt_q == LAST_ADDR);
	assign status.pipe_busy = v_s1 || v_s2 || v_s3;
	assign packed_rgba      = packed_q;
	assign nearest_index    = nearest_q;

endmodule

// File: design/nps_ctrl.sv
// controller: handshakes, scan sequencing and result slot
module nps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	output logic                out_valid,
	input  logic                out_ready,
	input  nps_pkg::dp_status_t status,
	output nps_pkg::ctrl_cmd_t  cmd
);
	import nps_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_type == REQ_QUERY)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.ram_write  = accept && (req_type == REQ_LOAD);
				cmd.out_pack   = accept && (req_type == REQ_LOAD);
				cmd.capture    = accept && (req_type == REQ_QUERY);
				cmd.scan_start = accept && (req_type == REQ_QUERY);
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_DRAIN: begin
				cmd.out_query = !status.pipe_busy && out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_pack || cmd.out_query) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
